### design/circdq_pkg.sv
// circdq_pkg: shared opcode and status codes and the result record of the circular deque
`timescale 1ns / 1ps
`default_nettype none
package circdq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int CFG_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     rd_ram;
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic                     is_empty;
    logic                     is_full;
  } res_t;

endpackage
`default_nettype wire

### design/circular_deque_core.sv
// circular_deque_core: top level of the ring-buffer deque with ram read stage and result register
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   in_opcode, in_value
//  out_     output     out_valid/out_stall out_data, out_status, out_is_empty, out_is_full
//  cfg_     input      cfg_valid/cfg_ready cfg_wdata (capacity_in_use)
//
//  one request per cycle while out_stall and cfg_valid are low; a taken request loads the ram read
//  and the read stage, then moves on into the result register, where its result is valid.
//  pointers live in flops and update at acceptance, so back-to-back requests need no bypass.
//  reset (synchronous, rst_n low) empties the deque and sets the capacity to CAPACITY or 16, whichever is smaller.
//  out_stall holds the result register, then the read stage, then in_stall rises.
//  in_stall is also high while cfg_valid is high.
`timescale 1ns / 1ps
`default_nettype none
module circular_deque_core #(
  parameter int CAPACITY = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [circdq_pkg::OP_W-1:0]          in_opcode,
  input  wire logic signed [circdq_pkg::DATA_W-1:0] in_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [circdq_pkg::DATA_W-1:0]      out_data,
  output logic [circdq_pkg::ST_W-1:0]               out_status,
  output logic                                      out_is_empty,
  output logic                                      out_is_full,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [circdq_pkg::CFG_W-1:0]         cfg_wdata
);
  import circdq_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic              in_acc;
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  res_t              res;

  logic pend_r, pend_nxt;
  res_t pend_res_r;
  logic pend_adv;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  assign cfg_ready = 1'b1;
  assign pend_adv  = pend_r && (!out_valid_r || !out_stall);
  assign in_stall  = (pend_r && !pend_adv) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;

  circdq_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_wdata  (cfg_wdata),
    .req_acc    (in_acc),
    .req_opcode (in_opcode),
    .req_value  (in_value),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .res        (res)
  );

  circdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc) begin
      pend_nxt = 1'b1;
    end else if (pend_adv) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (pend_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    out_res_nxt = pend_res_r;
    if (pend_res_r.rd_ram) begin
      out_res_nxt.data = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_res_r <= res;
    end
    if (pend_adv) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_res_r.data;
  assign out_status   = out_res_r.status;
  assign out_is_empty = out_res_r.is_empty;
  assign out_is_full  = out_res_r.is_full;

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.is_empty && out_res_r.is_full))
    else $error("result reports both empty and full");

  a_empty_refusal_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && pend_res_r.status == ST_EMPTY) |-> pend_res_r.is_empty)
    else $error("refused pop or peek left deque non-empty");

  a_ram_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && pend_res_r.rd_ram) |-> (pend_res_r.status == ST_OK))
    else $error("ram read issued for a refused request");

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !pend_adv) |=> pend_r && $stable(pend_res_r))
    else $error("read stage lost its request while stalled");
`endif

endmodule
`default_nettype wire

### design/circdq_ram.sv
// circdq_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module circdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/circdq_ctrl.sv
// circdq_ctrl: head and tail pointers, empty flag, capacity register and ram commands
`timescale 1ns / 1ps
`default_nettype none
module circdq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [circdq_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                                req_acc,
  input  wire logic [circdq_pkg::OP_W-1:0]         req_opcode,
  input  wire logic signed [circdq_pkg::DATA_W-1:0] req_value,
  output logic                                     ram_we,
  output logic [IW-1:0]                            ram_waddr,
  output logic [circdq_pkg::DATA_W-1:0]            ram_wdata,
  output logic                                     ram_re,
  output logic [IW-1:0]                            ram_raddr,
  output circdq_pkg::res_t                         res
);
  import circdq_pkg::*;

  localparam int CW = ($clog2(CAPACITY + 1) > CFG_W) ? $clog2(CAPACITY + 1) : CFG_W;
  localparam logic [CW-1:0] CAP_MAX   = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_RESET = (CAPACITY < 16) ? CW'(CAPACITY) : CW'(16);

  logic [CW-1:0] cap_r, cap_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic [CW-1:0] cfg_ext;

  function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i, input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = CW'(i) + CW'(1);
    return (s >= c) ? '0 : s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i,
                                              input logic [CW-1:0] c);
    logic [CW-1:0] m;
    m = c - CW'(1);
    return (i == '0) ? m[IW-1:0] : i - IW'(1);
  endfunction

  assign cfg_ext = CW'(cfg_wdata);

  always_comb begin
    cap_nxt   = cap_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = req_value;
    ram_re    = 1'b0;
    ram_raddr = head_r;
    res.rd_ram = 1'b0;
    res.data   = '0;
    res.status = ST_OK;
    if (cfg_we) begin
      if (cfg_ext == '0) begin
        cap_nxt = CW'(1);
      end else if (cfg_ext > CAP_MAX) begin
        cap_nxt = CAP_MAX;
      end else begin
        cap_nxt = cfg_ext;
      end
      head_nxt  = '0;
      tail_nxt  = '0;
      empty_nxt = 1'b1;
    end else if (req_acc) begin
      case (req_opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
            ram_we    = 1'b1;
            ram_waddr = '0;
            res.data  = req_value;
          end else if (step_up(tail_r, cap_r) == head_r) begin
            res.status = ST_FULL;
          end else if (req_opcode == OP_PUSH_FRONT) begin
            head_nxt  = step_down(head_r, cap_r);
            ram_we    = 1'b1;
            ram_waddr = head_nxt;
            res.data  = req_value;
          end else begin
            tail_nxt  = step_up(tail_r, cap_r);
            ram_we    = 1'b1;
            ram_waddr = tail_nxt;
            res.data  = req_value;
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
          if (empty_r) begin
            res.status = ST_EMPTY;
            if (req_opcode inside {OP_PEEK_FRONT, OP_PEEK_BACK}) begin
              res.data = -32'sd1;
            end
          end else begin
            ram_re     = 1'b1;
            res.rd_ram = 1'b1;
            ram_raddr  = (req_opcode inside {OP_POP_FRONT, OP_PEEK_FRONT}) ? head_r : tail_r;
            if (req_opcode inside {OP_POP_FRONT, OP_POP_BACK}) begin
              if (head_r == tail_r) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                empty_nxt = 1'b1;
              end else if (req_opcode == OP_POP_FRONT) begin
                head_nxt = step_up(head_r, cap_r);
              end else begin
                tail_nxt = step_down(tail_r, cap_r);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.is_empty = empty_nxt;
    res.is_full  = !empty_nxt && (step_up(tail_nxt, cap_nxt) == head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule
`default_nettype wire

### tb/tb_circular_deque_core.sv
// tb_circular_deque_core: self-checking testbench of the circular deque core with a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_circular_deque_core;
  import circdq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int LATENCY = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic                     is_empty;
    logic                     is_full;
  } deque_result_t;

  typedef struct {
    bit                       is_cfg;
    logic [CFG_W-1:0]         cfg_val;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;
    bit                       typed;
    deque_result_t            exp;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] in_opcode;
  logic signed [DATA_W-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_data;
  logic [ST_W-1:0] out_status;
  logic out_is_empty;
  logic out_is_full;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_wdata;

  // predictor state
  logic signed [DATA_W-1:0] ring_words [CAPACITY];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  bit deque_vacant;
  logic [CFG_W-1:0] cap_setting;

  deque_result_t pending_results[$];
  script_row_t directed_script[$];
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  circular_deque_core #(.CAPACITY(CAPACITY)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .out_status  (out_status),
    .out_is_empty(out_is_empty),
    .out_is_full (out_is_full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned active_capacity();
    int unsigned c;
    c = cap_setting;
    if (c < 1) c = 1;
    if (c > CAPACITY) c = CAPACITY;
    return c;
  endfunction

  function automatic int unsigned ring_next(int unsigned i, int unsigned c);
    return (i + 1 >= c) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned i, int unsigned c);
    return (i == 0) ? c - 1 : i - 1;
  endfunction

  function automatic bit deque_at_limit(int unsigned c);
    return !deque_vacant && ring_next(tail_ptr, c) == head_ptr;
  endfunction

  function automatic void empty_deque();
    head_ptr = 0;
    tail_ptr = 0;
    deque_vacant = 1'b1;
  endfunction

  function automatic void add_row(script_row_t row);
    directed_script.insert(directed_script.size(), row);
  endfunction

  function automatic deque_result_t apply_deque_op(logic [OP_W-1:0] op,
                                                   logic signed [DATA_W-1:0] val);
    deque_result_t r;
    int unsigned c;
    c = active_capacity();
    r.data = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (deque_vacant) begin
          empty_deque();
          deque_vacant = 1'b0;
          ring_words[0] = val;
          r.data = val;
        end else if (deque_at_limit(c)) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          head_ptr = ring_prev(head_ptr, c);
          ring_words[head_ptr] = val;
          r.data = val;
        end else begin
          tail_ptr = ring_next(tail_ptr, c);
          ring_words[tail_ptr] = val;
          r.data = val;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (deque_vacant) begin
          r.status = ST_EMPTY;
          r.data = (op == OP_PEEK_FRONT || op == OP_PEEK_BACK) ? -32'sd1 : 32'sd0;
        end else begin
          r.data = (op == OP_POP_FRONT || op == OP_PEEK_FRONT) ?
                   ring_words[head_ptr] : ring_words[tail_ptr];
          if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
            if (head_ptr == tail_ptr) empty_deque();
            else if (op == OP_POP_FRONT) head_ptr = ring_next(head_ptr, c);
            else tail_ptr = ring_prev(tail_ptr, c);
          end
        end
      end
      default: ;
    endcase
    r.is_empty = deque_vacant;
    r.is_full = deque_at_limit(c);
    return r;
  endfunction

  function automatic script_row_t op_row(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                                         bit typed, logic signed [DATA_W-1:0] d,
                                         logic [ST_W-1:0] st, logic e, logic f);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_val = '0;
    row.op = op;
    row.val = val;
    row.typed = typed;
    row.exp = '{d, st, e, f};
    return row;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_W-1:0] v);
    script_row_t row;
    row = op_row(OP_PEEK_FRONT, '0, 1'b0, '0, ST_OK, 1'b0, 1'b0);
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // push-heavy, pop-heavy or balanced mixes
  function automatic logic [OP_W-1:0] pick_op(int mix);
    int r;
    int push_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    push_pct = (mix == 0) ? 70 : (mix == 1) ? 20 : 42;
    pop_pct = (mix == 0) ? 15 : (mix == 1) ? 55 : 30;
    if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    if (r < 97) return $urandom_range(0, 1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
    return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                              bit typed, deque_result_t typed_exp);
    deque_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_opcode = op;
    in_value = val;
    do @(posedge clk); while (in_stall);
    predicted = apply_deque_op(op, val);
    pending_results.insert(pending_results.size(), typed ? typed_exp : predicted);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_wdata = v;
    do @(posedge clk); while (!cfg_ready);
    cap_setting = v;
    empty_deque();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    deque_result_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: data=%0d status=%0d empty=%0b full=%0b",
                   out_data, out_status, out_is_empty, out_is_full);
      end else begin
        exp = pending_results[0];
        pending_results.delete(0);
        if (out_data !== exp.data || out_status !== exp.status ||
            out_is_empty !== exp.is_empty || out_is_full !== exp.is_full) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp data=%0d status=%0d empty=%0b full=%0b",
                     exp.data, exp.status, exp.is_empty, exp.is_full);
            $display("          got data=%0d status=%0d empty=%0b full=%0b",
                     out_data, out_status, out_is_empty, out_is_full);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] cap_plan [18];
    int seg;
    int mix;
    int n_items;
    deque_result_t no_exp;
    cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd3, 5'd15, 5'd8,
                 5'd5, 5'd16, 5'd4, 5'd1, 5'd31, 5'd7, 5'd12, 5'd16, 5'd0};
    no_exp = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_PUSH_FRONT;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_wdata = '0;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 15;
    recv_idle_pct = 57;
    for (int i = 0; i < CAPACITY; i++) ring_words[i] = '0;
    empty_deque();
    cap_setting = 5'd16;

    // empty deque, extremes, spare opcodes, single-entry capacity, capacity write clears
    add_row(op_row(OP_PEEK_FRONT, 32'sd9, 1, -32'sd1, ST_EMPTY, 1, 0));
    add_row(op_row(OP_PEEK_BACK, 32'sd9, 1, -32'sd1, ST_EMPTY, 1, 0));
    add_row(op_row(OP_POP_FRONT, 32'sd9, 1, 32'sd0, ST_EMPTY, 1, 0));
    add_row(op_row(OP_POP_BACK, 32'sd9, 1, 32'sd0, ST_EMPTY, 1, 0));
    add_row(op_row(OP_PUSH_BACK, 32'sh7fffffff, 1, 32'sh7fffffff, ST_OK, 0, 0));
    add_row(op_row(OP_PUSH_FRONT, 32'sh80000000, 1, 32'sh80000000, ST_OK, 0, 0));
    add_row(op_row(OP_PEEK_FRONT, 32'sd0, 0, '0, ST_OK, 0, 0));
    add_row(op_row(OP_PEEK_BACK, 32'sd0, 0, '0, ST_OK, 0, 0));
    add_row(op_row(OP_SPARE_6, -32'sd1, 1, 32'sd0, ST_OK, 0, 0));
    add_row(op_row(OP_SPARE_7, 32'sh12345678, 1, 32'sd0, ST_OK, 0, 0));
    add_row(op_row(OP_POP_BACK, 32'sd0, 0, '0, ST_OK, 0, 0));
    add_row(op_row(OP_POP_FRONT, 32'sd0, 0, '0, ST_OK, 0, 0));
    add_row(cfg_row(5'd1));
    add_row(op_row(OP_PUSH_FRONT, 32'sh55555555, 1, 32'sh55555555, ST_OK, 0, 1));
    add_row(op_row(OP_PUSH_BACK, 32'shaaaaaaaa, 1, 32'sd0, ST_FULL, 0, 1));
    add_row(op_row(OP_PEEK_BACK, 32'sd0, 0, '0, ST_OK, 0, 0));
    add_row(cfg_row(5'd0));
    add_row(op_row(OP_PUSH_BACK, -32'sd1, 1, -32'sd1, ST_OK, 0, 1));
    add_row(op_row(OP_PUSH_FRONT, 32'sd0, 1, 32'sd0, ST_FULL, 0, 1));
    add_row(op_row(OP_POP_FRONT, 32'sd0, 0, '0, ST_OK, 0, 0));
    add_row(cfg_row(5'd31));
    add_row(op_row(OP_PUSH_BACK, 32'sd1, 0, '0, ST_OK, 0, 0));
    add_row(op_row(OP_PUSH_FRONT, 32'sd2, 0, '0, ST_OK, 0, 0));
    add_row(op_row(OP_POP_FRONT, 32'sd0, 0, '0, ST_OK, 0, 0));
    add_row(op_row(OP_POP_BACK, 32'sd0, 0, '0, ST_OK, 0, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_script[i]) begin
      if (directed_script[i].is_cfg)
        write_capacity(directed_script[i].cfg_val);
      else
        send_request(directed_script[i].op, directed_script[i].val,
                     directed_script[i].typed, directed_script[i].exp);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 15 : 0;
      for (int s = 0; s < 6; s++) begin
        seg = phase * 6 + s;
        write_capacity(cap_plan[seg]);
        n_items = $urandom_range(80, 120);
        for (int k = 0; k < n_items; k++) begin
          // sweep fill and drain within each segment
          mix = (k < n_items / 3) ? 0 : (k < 2 * n_items / 3) ? 1 : 2;
          send_request(pick_op(mix), pick_word(), 1'b0, no_exp);
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
